@@ rtl/rrts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types, sizes and helpers for the round-robin time-slice scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // dispatch list size and derived widths
  localparam int unsigned MAX_TASKS   = 16;
  localparam int unsigned IDX_W       = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W       = $clog2(MAX_TASKS + 1);

  // fixed field widths
  localparam int unsigned ID_W        = 8;
  localparam int unsigned QUANT_W     = 8;
  localparam int unsigned COUNT_OUT_W = 5;

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = QUANT_W'(4);

  // operation codes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  // one result beat
  typedef struct packed {
    logic                   done;
    logic [ID_W-1:0]        cur_task;
    logic                   cur_valid;
    logic                   switched;
    logic                   error;
    logic [COUNT_OUT_W-1:0] count;
  } rrts_res_t;

  // physical slot of list position off, list starting at slot base
  function automatic logic [IDX_W-1:0] idx_wrap(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = (IDX_W+1)'(base) + (IDX_W+1)'(off);
    if (sum >= (IDX_W+1)'(MAX_TASKS)) begin
      sum = sum - (IDX_W+1)'(MAX_TASKS);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/rrts_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/rrts_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_seq
// Sequencer: keeps the list as a ring in the RAM, runs tick/add/remove as
// read-modify-write steps and registers the result beat.
// ----------------------------------------------------------------------------
module rrts_seq (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [1:0]                  operation_i,
  input  wire logic [rrts_pkg::ID_W-1:0]   task_id_i,
  input  wire logic [rrts_pkg::QUANT_W-1:0] quantum_i,
  output logic                             mem_we_o,
  output logic [rrts_pkg::IDX_W-1:0]       mem_waddr_o,
  output logic [rrts_pkg::ID_W-1:0]        mem_wdata_o,
  output logic [rrts_pkg::IDX_W-1:0]       mem_raddr_o,
  input  wire logic [rrts_pkg::ID_W-1:0]   mem_rdata_i,
  output rrts_pkg::rrts_res_t              res_o
);

  import rrts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT_RD,
    ST_SEARCH,
    ST_HEAD_RD,
    ST_SHIFT
  } state_e;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [QUANT_W-1:0]  slice_q, slice_d;
  logic [ID_W-1:0]     cur_q, cur_d;
  logic                has_q, has_d;
  logic [ID_W-1:0]     id_q, id_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  rrts_res_t           res_q, res_d;

  // next state, memory requests and result beat
  always_comb begin
    logic [QUANT_W-1:0] slice_dec;
    logic [CNT_W-1:0]   nxt;
    logic               fin;
    logic               err;

    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    slice_d     = slice_q;
    cur_d       = cur_q;
    has_d       = has_q;
    id_d        = id_q;
    idx_d       = idx_q;
    res_d       = res_q;
    res_d.done  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = head_q;
    mem_wdata_o = cur_q;
    mem_raddr_o = head_q;
    slice_dec   = (slice_q != '0) ? slice_q - QUANT_W'(1) : '0;
    nxt         = idx_q + CNT_W'(1);
    fin         = 1'b0;
    err         = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          id_d = task_id_i;
          unique case (op_e'(operation_i))
            OP_TICK: begin
              fin = 1'b1;
              if (count_q != '0) begin
                if (slice_dec == '0) begin
                  slice_d = quantum_i;
                  if (count_q != CNT_W'(1)) begin
                    // old head goes to the tail, then fetch the new head
                    mem_we_o    = 1'b1;
                    mem_waddr_o = idx_wrap(head_q, count_q);
                    mem_wdata_o = cur_q;
                    head_d      = idx_wrap(head_q, CNT_W'(1));
                    mem_raddr_o = idx_wrap(head_q, CNT_W'(1));
                    fin         = 1'b0;
                    state_d     = ST_ROT_RD;
                  end
                end else begin
                  slice_d = slice_dec;
                end
              end
            end
            OP_ADD: begin
              fin = 1'b1;
              if (count_q >= CNT_W'(MAX_TASKS)) begin
                err = 1'b1;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = idx_wrap(head_q, count_q);
                mem_wdata_o = task_id_i;
                count_d     = count_q + CNT_W'(1);
                if (!has_q) begin
                  cur_d   = task_id_i;
                  has_d   = 1'b1;
                  slice_d = quantum_i;
                end
              end
            end
            OP_REMOVE: begin
              if (count_q == '0) begin
                fin = 1'b1;
                err = 1'b1;
              end else begin
                // start the scan at the head
                mem_raddr_o = head_q;
                idx_d       = '0;
                state_d     = ST_SEARCH;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      ST_ROT_RD: begin
        cur_d   = mem_rdata_i;
        fin     = 1'b1;
        state_d = ST_IDLE;
      end

      ST_SEARCH: begin
        // read data belongs to idx_q; fetch the next entry ahead
        mem_raddr_o = idx_wrap(head_q, nxt);
        if (mem_rdata_i == id_q) begin
          if (idx_q == '0) begin
            if (count_q == CNT_W'(1)) begin
              count_d = '0;
              has_d   = 1'b0;
              cur_d   = '0;
              slice_d = quantum_i;
              fin     = 1'b1;
              state_d = ST_IDLE;
            end else begin
              // dropping the head only advances the ring
              head_d  = idx_wrap(head_q, CNT_W'(1));
              count_d = count_q - CNT_W'(1);
              state_d = ST_HEAD_RD;
            end
          end else if (nxt == count_q) begin
            count_d = count_q - CNT_W'(1);
            fin     = 1'b1;
            state_d = ST_IDLE;
          end else begin
            idx_d   = nxt;
            state_d = ST_SHIFT;
          end
        end else if (nxt == count_q) begin
          err     = 1'b1;
          fin     = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d = nxt;
        end
      end

      ST_HEAD_RD: begin
        cur_d   = mem_rdata_i;
        slice_d = quantum_i;
        fin     = 1'b1;
        state_d = ST_IDLE;
      end

      ST_SHIFT: begin
        // move entry idx_q down one place, fetch the one after it
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_wrap(head_q, idx_q - CNT_W'(1));
        mem_wdata_o = mem_rdata_i;
        mem_raddr_o = idx_wrap(head_q, nxt);
        if (nxt == count_q) begin
          count_d = count_q - CNT_W'(1);
          fin     = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d = nxt;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // result beat
    if (fin) begin
      res_d.done      = 1'b1;
      res_d.cur_task  = has_d ? cur_d : '0;
      res_d.cur_valid = has_d;
      res_d.switched  = (has_d != has_q) || (cur_d != cur_q);
      res_d.error     = err;
      res_d.count     = COUNT_OUT_W'(count_d);
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      slice_q <= QUANTUM_RESET;
      cur_q   <= '0;
      has_q   <= 1'b0;
      id_q    <= '0;
      idx_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      slice_q <= slice_d;
      cur_q   <= cur_d;
      has_q   <= has_d;
      id_q    <= id_d;
      idx_q   <= idx_d;
      res_q   <= res_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign res_o  = res_q;

endmodule
`default_nettype wire

@@ rtl/round_robin_time_slice_scheduler_unit.sv @@
`default_nettype none
// The result beat shows in the cycle after the item is taken for add, non-rotating tick,
// invalid codes and remove on an empty list; a rotating tick writes the old head to the
// tail, then reads the new head in ST_ROT_RD. Remove scans and compacts the list through
// the RAM one entry per cycle while busy is high; its beat shows in the cycle busy falls.
// A new item can be taken in the cycle its result beat shows; beats cannot be stalled.
// Reset empties the list, clears the current task and loads quantum and slice with 4.
// ----------------------------------------------------------------------------
// round_robin_time_slice_scheduler_unit
// Round-robin dispatch list with per-task time slice; top level.
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     operation_i,
  input  wire logic [rrts_pkg::ID_W-1:0]      task_id_i,
  input  wire logic                           quantum_we_i,
  input  wire logic [rrts_pkg::QUANT_W-1:0]   quantum_i,
  output logic                                done_o,
  output logic [rrts_pkg::ID_W-1:0]           current_task_o,
  output logic                                current_valid_o,
  output logic                                switched_o,
  output logic                                error_o,
  output logic [rrts_pkg::COUNT_OUT_W-1:0]    task_count_o
);

  import rrts_pkg::*;

  logic [QUANT_W-1:0] quantum_q, quantum_d;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ID_W-1:0]    mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ID_W-1:0]    mem_rdata;
  rrts_res_t          res;

  // quantum register
  assign quantum_d = quantum_we_i ? quantum_i : quantum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RESET;
    end else begin
      quantum_q <= quantum_d;
    end
  end

  // dispatch list storage
  rrts_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_TASKS)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequencer
  rrts_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .operation_i (operation_i),
    .task_id_i   (task_id_i),
    .quantum_i   (quantum_q),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_o       (res)
  );

  // result ports
  assign done_o          = res.done;
  assign current_task_o  = res.cur_task;
  assign current_valid_o = res.cur_valid;
  assign switched_o      = res.switched;
  assign error_o         = res.error;
  assign task_count_o    = res.count;

endmodule
`default_nettype wire

@@ rtl/rrts_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrts_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic                           busy_i,
  input  wire logic [1:0]                     operation_i,
  input  wire logic                           done_i,
  input  wire logic [rrts_pkg::ID_W-1:0]      current_task_i,
  input  wire logic                           current_valid_i,
  input  wire logic [rrts_pkg::COUNT_OUT_W-1:0] task_count_i
);

  import rrts_pkg::*;

  // a finished beat always returns the block to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy_i)
    else $error("result beat while busy");

  // add answers in the cycle after it is taken
  a_add_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i && (operation_i == OP_ADD)) |=> done_i)
    else $error("add did not answer in the next cycle");

  // a current task exists exactly when the list is not empty
  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> (current_valid_i == (task_count_i != '0)))
    else $error("current valid does not match task count");

  // no current task reads as id zero
  a_idle_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && !current_valid_i) |-> (current_task_i == '0))
    else $error("stale id with no current task");

endmodule

bind round_robin_time_slice_scheduler_unit rrts_checker u_rrts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start),
  .busy_i          (busy),
  .operation_i     (operation_i),
  .done_i          (done_o),
  .current_task_i  (current_task_o),
  .current_valid_i (current_valid_o),
  .task_count_i    (task_count_o)
);
`default_nettype wire

@@ tb/round_robin_time_slice_scheduler_unit_tb.sv @@
// ----------------------------------------------------------------------------
// round_robin_time_slice_scheduler_unit_tb
// Self-checking bench for the time-slice scheduler. A scoreboard tracks the
// dispatch list, slice and current task, and predicts each result beat. A
// short directed run is followed by random phases at several quantum values
// and sender idle rates. Each done beat is checked against the prediction.
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrts_pkg::*;

  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int          PHASE_COUNT   = 6;
  localparam int          PHASE_ITEMS   = 315;
  localparam int          SETTLE_CYCLES = 2 * MAX_TASKS + 8;
  localparam int unsigned CYCLE_LIMIT   = 500000;

  // operation mix per stimulus mode
  localparam int MODE_FILL     = 0;
  localparam int MODE_DRAIN    = 1;
  localparam int MODE_BALANCED = 2;

  typedef struct {
    logic [ID_W-1:0]        cur_task;
    logic                   cur_valid;
    logic                   switched;
    logic                   error;
    logic [COUNT_OUT_W-1:0] count;
  } sched_beat_t;

  // scheduler state tracker and result queue
  class sched_scoreboard;
    logic [ID_W-1:0]    dispatch_q[$];
    logic [QUANT_W-1:0] quantum;
    logic [QUANT_W-1:0] slice_left;
    logic [ID_W-1:0]    cur_id;
    logic               cur_valid;
    sched_beat_t        pending_q[$];
    int unsigned        mismatches;

    function new();
      quantum    = QUANTUM_RESET;
      slice_left = QUANTUM_RESET;
      cur_id     = '0;
      cur_valid  = 1'b0;
      mismatches = 0;
    endfunction

    // head of the list becomes current with a fresh slice
    function void load_head();
      if (dispatch_q.size() > 0) begin
        cur_id    = dispatch_q[0];
        cur_valid = 1'b1;
      end else begin
        cur_id    = '0;
        cur_valid = 1'b0;
      end
      slice_left = quantum;
    endfunction

    function void note_item(logic [1:0] op, logic [ID_W-1:0] id);
      logic [ID_W-1:0] prev_id;
      logic            prev_valid;
      logic            err;
      logic [ID_W-1:0] head;
      int              pos;
      sched_beat_t     beat;
      prev_id    = cur_id;
      prev_valid = cur_valid;
      err        = 1'b0;
      case (op)
        OP_TICK: begin
          if (dispatch_q.size() > 0) begin
            if (slice_left != 0) slice_left = slice_left - 1'b1;
            // slice used up: rotate head to tail
            if (slice_left == 0) begin
              head = dispatch_q.pop_front();
              dispatch_q.push_back(head);
              load_head();
            end
          end
        end
        OP_ADD: begin
          if (dispatch_q.size() >= MAX_TASKS) begin
            err = 1'b1;
          end else begin
            dispatch_q.push_back(id);
            if (!cur_valid) load_head();
          end
        end
        OP_REMOVE: begin
          // first match only, order of the rest kept
          pos = -1;
          foreach (dispatch_q[i]) if (pos < 0 && dispatch_q[i] == id) pos = i;
          if (pos < 0) begin
            err = 1'b1;
          end else begin
            dispatch_q.delete(pos);
            if (pos == 0) load_head();
          end
        end
        default: ;
      endcase
      beat.cur_task  = cur_valid ? cur_id : '0;
      beat.cur_valid = cur_valid;
      beat.switched  = (cur_valid != prev_valid) || (cur_id != prev_id);
      beat.error     = err;
      beat.count     = COUNT_OUT_W'(dispatch_q.size());
      pending_q.push_back(beat);
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_beat(logic [ID_W-1:0] task_v, logic valid_v, logic sw_v,
                             logic err_v, logic [COUNT_OUT_W-1:0] cnt_v);
      sched_beat_t beat;
      if (pending_q.size() == 0) begin
        $error("result beat with no item outstanding");
        mismatches++;
        return;
      end
      beat = pending_q.pop_front();
      compare_field("current_task", 8'(beat.cur_task), 8'(task_v));
      compare_field("current_valid", 8'(beat.cur_valid), 8'(valid_v));
      compare_field("switched", 8'(beat.switched), 8'(sw_v));
      compare_field("error", 8'(beat.error), 8'(err_v));
      compare_field("task_count", 8'(beat.count), 8'(cnt_v));
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [1:0]             operation_i;
  logic [ID_W-1:0]        task_id_i;
  logic                   quantum_we_i;
  logic [QUANT_W-1:0]     quantum_i;
  logic                   done_o;
  logic [ID_W-1:0]        current_task_o;
  logic                   current_valid_o;
  logic                   switched_o;
  logic                   error_o;
  logic [COUNT_OUT_W-1:0] task_count_o;

  sched_scoreboard sched = new();
  int unsigned     cycle_count;

  round_robin_time_slice_scheduler_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .task_id_i       (task_id_i),
    .quantum_we_i    (quantum_we_i),
    .quantum_i       (quantum_i),
    .done_o          (done_o),
    .current_task_o  (current_task_o),
    .current_valid_o (current_valid_o),
    .switched_o      (switched_o),
    .error_o         (error_o),
    .task_count_o    (task_count_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      sched.check_beat(current_task_o, current_valid_o, switched_o, error_o, task_count_o);
    end
  end

  // present one beat and hold it until taken
  task automatic send_item(logic [1:0] op, logic [ID_W-1:0] id);
    start       <= 1'b1;
    operation_i <= op;
    task_id_i   <= id;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    sched.note_item(op, id);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // wait for every outstanding result, then let the block go quiet
  task automatic settle();
    start <= 1'b0;
    while (sched.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_quantum(logic [QUANT_W-1:0] q);
    quantum_we_i <= 1'b1;
    quantum_i    <= q;
    @(posedge clk_i);
    quantum_we_i <= 1'b0;
    sched.quantum = q;
  endtask

  // mostly a small id pool so duplicates and hits are common
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 99) < 65) return ID_W'($urandom_range(0, 7));
    return ID_W'($urandom_range(0, 255));
  endfunction

  task automatic send_random(int mode);
    logic [1:0] op;
    logic [ID_W-1:0] id;
    int r;
    int add_th;
    int rem_th;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  begin add_th = 20; rem_th = 75; end
      MODE_DRAIN: begin add_th = 20; rem_th = 35; end
      default:    begin add_th = 45; rem_th = 70; end
    endcase
    if (r < add_th) op = OP_TICK;
    else if (r < rem_th) op = (mode == MODE_DRAIN) ? OP_ADD : OP_ADD;
    else if (r < 95) op = OP_REMOVE;
    else op = OP_UNUSED;
    // drain mode: removes take the remove band
    if (mode == MODE_DRAIN && r >= rem_th && r < 95) op = OP_REMOVE;
    if (mode == MODE_DRAIN && r >= add_th && r < rem_th) op = OP_ADD;
    if (op == OP_REMOVE && sched.dispatch_q.size() > 0 && $urandom_range(0, 3) != 0) begin
      id = sched.dispatch_q[$urandom_range(0, sched.dispatch_q.size() - 1)];
    end else begin
      id = pick_id();
    end
    send_item(op, id);
  endtask

  initial begin
    logic [QUANT_W-1:0] phase_quantum[PHASE_COUNT];
    int                 idle_pct[PHASE_COUNT];
    int                 mode;
    bit                 quiet;
    phase_quantum = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd0, 8'd3};
    idle_pct      = '{0, 70, 0, 12, 70, 0};
    phase_quantum[4] = QUANT_W'($urandom_range(1, 255));
    cycle_count   = 0;
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    operation_i  <= OP_TICK;
    task_id_i    <= '0;
    quantum_we_i <= 1'b0;
    quantum_i    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_quantum(QUANTUM_RESET);

    // directed: empty list, duplicates, rotation, removals, unused code
    send_item(OP_TICK, 8'd0);
    send_item(OP_REMOVE, 8'd0);
    send_item(OP_ADD, 8'd0);
    send_item(OP_ADD, 8'd255);
    send_item(OP_ADD, 8'd255);
    repeat (4) send_item(OP_TICK, 8'd255);
    send_item(OP_ADD, 8'h55);
    send_item(OP_REMOVE, 8'd255);
    send_item(OP_REMOVE, 8'h55);
    send_item(OP_UNUSED, 8'hAA);
    send_item(OP_REMOVE, 8'd0);
    send_item(OP_REMOVE, 8'd255);
    send_item(OP_REMOVE, 8'd77);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_ADD, 8'hAA);
    send_item(OP_UNUSED, 8'h55);

    // random phases, one quantum setting each
    for (int p = 0; p < PHASE_COUNT; p++) begin
      settle();
      write_quantum(phase_quantum[p]);
      mode  = MODE_BALANCED;
      quiet = 1'b0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) begin
          mode  = $urandom_range(0, 2);
          quiet = ($urandom_range(0, 3) == 0);
        end
        send_random(mode);
        if (!quiet && $urandom_range(0, 99) < idle_pct[p]) idle_cycles($urandom_range(1, 6));
      end
    end

    settle();
    if (sched.pending_q.size() != 0) begin
      $error("%0d expected beats never arrived", sched.pending_q.size());
      sched.mismatches++;
    end
    if (sched.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rrts_pkg.sv
rtl/rrts_ram.sv
rtl/rrts_seq.sv
rtl/round_robin_time_slice_scheduler_unit.sv
rtl/rrts_checker.sv
tb/round_robin_time_slice_scheduler_unit_tb.sv
